// File: rtl/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_LONG_DELAY  = 2'd0;
  localparam logic [1:0] REG_SHORT_DELAY = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

  localparam logic [7:0] LongDelayRst  = 8'd2;
  localparam logic [7:0] ShortDelayRst = 8'd1;
  localparam logic [7:0] AckTimeoutRst = 8'd250;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WAIT_ACK = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST1  = 4'd1,
    PH_ST2  = 4'd2,
    PH_SP1  = 4'd3,
    PH_SP2  = 4'd4,
    PH_WLO  = 4'd5,
    PH_WHI  = 4'd6,
    PH_WTL  = 4'd7,
    PH_RLO  = 4'd8,
    PH_RHI  = 4'd9,
    PH_RTL  = 4'd10,
    PH_ALO  = 4'd11,
    PH_AHI  = 4'd12,
    PH_WA1  = 4'd13,
    PH_WA2  = 4'd14,
    PH_POLL = 4'd15
  } phase_e;

  typedef struct packed {
    logic [7:0] long_delay;
    logic [7:0] short_delay;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] bit_index;
    logic [7:0] shift_reg;
    logic [7:0] delay_count;
    logic [7:0] poll_count;
    logic       scl;
    logic       sda;
    logic       sda_dir;
    logic       ack_choice;
    logic       fail;
  } eng_state_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  // Result beat, packed into tdata with the last field (scl_level) in the lowest bits
  typedef struct packed {
    logic       ack_failed;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } res_t;

  localparam int unsigned ResW   = $bits(res_t);
  localparam int unsigned MDataW = ((ResW + 7) / 8) * 8;

endpackage
`default_nettype wire

// File: rtl/i2c_master_bit_engine_core.sv
`default_nettype none
// Latency: a result beat is valid on m_axis the cycle after its tick beat is taken.
// Throughput: one tick beat per clock while s_axis_tready is high; the step logic is a single pass from the
//   engine state register to the result register.
// Back-pressure: s_axis_tready drops only while a result waits and m_axis_tready is low.
// Reset (rst_ni, async, active low): engine idle, SCL/SDA released high, SDA driven,
//   delay registers back to long 2, short 1, ACK timeout 250; no result pending.
module i2c_master_bit_engine_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tick beats
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
  input  wire logic [15:0]                   s_axis_tdata,
  // [2:0] command
  input  wire logic [2:0]                    s_axis_tuser,
  // result beats
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_failed, [15:14] zero
  output logic [i2cm_pkg::MDataW-1:0]        m_axis_tdata,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [i2cm_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [i2cm_pkg::CfgDataW-1:0] pwdata,
  output logic      [i2cm_pkg::CfgDataW-1:0] prdata,
  output logic                               pready
);
  import i2cm_pkg::*;

  cfg_t       cfg;
  tick_t      tick;
  eng_state_t st_q, st_d, st_nxt;
  res_t       res_q, res_d, res_nxt;
  logic       m_valid_q, m_valid_d;
  logic       take_tick;

  // Delay and timeout registers behind the APB port
  i2cm_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Unpack the tick beat: command from tuser, the rest from tdata
  assign tick = {s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8], s_axis_tdata[9]};

  // One result slot; a new tick is taken when the slot is empty or drains this cycle
  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign take_tick     = s_axis_tvalid & s_axis_tready;

  // Combinational step: state plus tick -> next state and result beat
  i2cm_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg),
    .tick_i (tick),
    .st_o   (st_nxt),
    .res_o  (res_nxt)
  );

  // Engine state only advances on an accepted tick
  always_comb begin
    st_d      = st_q;
    res_d     = res_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    if (take_tick) begin
      st_d      = st_nxt;
      res_d     = res_nxt;
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= PH_IDLE;
      st_q.bit_index   <= '0;
      st_q.shift_reg   <= '0;
      st_q.delay_count <= '0;
      st_q.poll_count  <= '0;
      st_q.scl         <= 1'b1;  // bus released
      st_q.sda         <= 1'b1;
      st_q.sda_dir     <= 1'b1;  // SDA as output
      st_q.ack_choice  <= 1'b0;
      st_q.fail        <= 1'b0;
      res_q            <= '0;
      m_valid_q        <= 1'b0;
    end else begin
      st_q      <= st_d;
      res_q     <= res_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(MDataW-ResW){1'b0}}, res_q};

endmodule
`default_nettype wire

// File: rtl/i2cm_cfg_regs.sv
`default_nettype none
module i2cm_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [i2cm_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [i2cm_pkg::CfgDataW-1:0] pwdata,
  output logic      [i2cm_pkg::CfgDataW-1:0] prdata,
  output logic                               pready,
  output i2cm_pkg::cfg_t                     cfg_o
);
  import i2cm_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_LONG_DELAY:  cfg_d.long_delay  = pwdata[7:0];
        REG_SHORT_DELAY: cfg_d.short_delay = pwdata[7:0];
        REG_ACK_TIMEOUT: cfg_d.ack_timeout = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_delay  <= LongDelayRst;
      cfg_q.short_delay <= ShortDelayRst;
      cfg_q.ack_timeout <= AckTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_LONG_DELAY:  prdata = {{(CfgDataW-8){1'b0}}, cfg_q.long_delay};
      REG_SHORT_DELAY: prdata = {{(CfgDataW-8){1'b0}}, cfg_q.short_delay};
      REG_ACK_TIMEOUT: prdata = {{(CfgDataW-8){1'b0}}, cfg_q.ack_timeout};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/i2cm_step.sv
`default_nettype none
// One bus tick: next engine state and the result beat.
module i2cm_step (
  input  wire i2cm_pkg::eng_state_t st_i,
  input  wire i2cm_pkg::cfg_t       cfg_i,
  input  wire i2cm_pkg::tick_t      tick_i,
  output i2cm_pkg::eng_state_t      st_o,
  output i2cm_pkg::res_t            res_o
);
  import i2cm_pkg::*;

  eng_state_t n;
  logic       done;
  logic       rx_valid;
  logic [3:0] bit_inc;
  logic [7:0] shl;

  assign bit_inc = st_i.bit_index + 4'd1;
  assign shl     = {st_i.shift_reg[6:0], 1'b0};

  always_comb begin
    n        = st_i;
    done     = 1'b0;
    rx_valid = 1'b0;
    if (st_i.phase == PH_IDLE) begin
      case (tick_i.command)
        CMD_START: begin
          n.sda_dir     = 1'b1;
          n.sda         = 1'b1;
          n.scl         = 1'b1;
          n.phase       = PH_ST1;
          n.delay_count = cfg_i.long_delay;
        end
        CMD_STOP: begin
          n.sda_dir     = 1'b1;
          n.scl         = 1'b0;
          n.sda         = 1'b0;
          n.phase       = PH_SP1;
          n.delay_count = cfg_i.long_delay;
        end
        CMD_WRITE: begin
          n.sda_dir     = 1'b1;
          n.scl         = 1'b0;
          n.shift_reg   = tick_i.tx_byte;
          n.bit_index   = '0;
          n.sda         = tick_i.tx_byte[7];
          n.phase       = PH_WLO;
          n.delay_count = cfg_i.long_delay;
        end
        CMD_READ: begin
          n.sda_dir     = 1'b0;
          n.scl         = 1'b0;
          n.ack_choice  = tick_i.send_ack;
          n.shift_reg   = '0;
          n.bit_index   = '0;
          n.phase       = PH_RLO;
          n.delay_count = cfg_i.long_delay;
        end
        CMD_WAIT_ACK: begin
          n.sda_dir     = 1'b0;
          n.sda         = 1'b1;
          n.poll_count  = '0;
          n.fail        = 1'b0;
          n.phase       = PH_WA1;
          n.delay_count = cfg_i.short_delay;
        end
        default: ;
      endcase
    end else if (st_i.phase == PH_POLL) begin
      if (!tick_i.sda_in) begin
        n.scl   = 1'b0;
        n.fail  = 1'b0;
        n.phase = PH_IDLE;
        done    = 1'b1;
      end else if (st_i.poll_count >= cfg_i.ack_timeout) begin
        // timeout: flag it and release the bus with a stop
        n.fail        = 1'b1;
        n.sda_dir     = 1'b1;
        n.scl         = 1'b0;
        n.sda         = 1'b0;
        n.phase       = PH_SP1;
        n.delay_count = cfg_i.long_delay;
      end else begin
        n.poll_count = st_i.poll_count + 8'd1;
      end
    end else if (st_i.delay_count > 8'd1) begin
      n.delay_count = st_i.delay_count - 8'd1;
    end else begin
      n.delay_count = cfg_i.long_delay;
      case (st_i.phase)
        PH_ST1: begin
          n.sda   = 1'b0;
          n.phase = PH_ST2;
        end
        PH_ST2: begin
          n.scl         = 1'b0;
          n.phase       = PH_IDLE;
          n.delay_count = st_i.delay_count;
          done          = 1'b1;
        end
        PH_SP1: begin
          n.scl   = 1'b1;
          n.sda   = 1'b1;
          n.phase = PH_SP2;
        end
        PH_SP2: begin
          n.phase       = PH_IDLE;
          n.delay_count = st_i.delay_count;
          done          = 1'b1;
        end
        PH_WLO: begin
          n.scl   = 1'b1;
          n.phase = PH_WHI;
        end
        PH_WHI: begin
          n.scl   = 1'b0;
          n.phase = PH_WTL;
        end
        PH_WTL: begin
          n.bit_index = bit_inc;
          if (bit_inc >= 4'd8) begin
            n.phase       = PH_IDLE;
            n.delay_count = st_i.delay_count;
            done          = 1'b1;
          end else begin
            n.shift_reg = shl;
            n.sda       = shl[7];
            n.phase     = PH_WLO;
          end
        end
        PH_RLO: begin
          n.scl       = 1'b1;
          n.shift_reg = {st_i.shift_reg[6:0], tick_i.sda_in};
          n.phase     = PH_RHI;
        end
        PH_RHI: begin
          n.scl   = 1'b0;
          n.phase = PH_RTL;
        end
        PH_RTL: begin
          n.bit_index = bit_inc;
          n.scl       = 1'b0;
          if (bit_inc >= 4'd8) begin
            n.sda_dir = 1'b1;
            n.sda     = ~st_i.ack_choice;
            n.phase   = PH_ALO;
          end else begin
            n.phase = PH_RLO;
          end
        end
        PH_ALO: begin
          n.scl   = 1'b1;
          n.phase = PH_AHI;
        end
        PH_AHI: begin
          n.scl         = 1'b0;
          n.phase       = PH_IDLE;
          n.delay_count = st_i.delay_count;
          done          = 1'b1;
          rx_valid      = 1'b1;
        end
        PH_WA1: begin
          n.scl         = 1'b1;
          n.phase       = PH_WA2;
          n.delay_count = cfg_i.short_delay;
        end
        PH_WA2: begin
          n.phase       = PH_POLL;
          n.delay_count = st_i.delay_count;
        end
        default: begin
          n.phase       = PH_IDLE;
          n.delay_count = st_i.delay_count;
        end
      endcase
    end
  end

  assign st_o = n;

  always_comb begin
    res_o.scl_level  = n.scl;
    res_o.sda_level  = n.sda;
    res_o.sda_drive  = n.sda_dir;
    res_o.busy_res   = (n.phase != PH_IDLE);
    res_o.done_res   = done;
    res_o.rx_byte    = rx_valid ? n.shift_reg : 8'd0;
    res_o.ack_failed = n.fail;
  end

endmodule
`default_nettype wire

// File: rtl/i2c_master_bit_engine_core_sva.sv
`default_nettype none
module i2c_master_bit_engine_core_sva (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // Input is only held off while a result beat is waiting
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("tick beat refused with no result pending");

  // Every accepted tick yields a result beat next cycle
  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted tick produced no result beat");

  // Stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

  // A completing command leaves the engine idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tdata[3])
    else $error("done reported while busy");

  // Received byte shows only on a done beat
  a_rx_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[12:5] != 8'd0)) |-> m_axis_tdata[4])
    else $error("rx byte outside done beat");

endmodule

bind i2c_master_bit_engine_core i2c_master_bit_engine_core_sva u_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
